// ----- sv/sri_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sri_pkg
// Types and constants shared by the instruction execute block.
// ----------------------------------------------------------------------------
package sri_pkg;

  localparam int unsigned PC_W = 21;
  localparam int unsigned DW   = 16;
  localparam int unsigned RW   = 5;

  typedef enum logic [4:0] {
    OP_STOP  = 5'd0,
    OP_ADD   = 5'd1,
    OP_SUB   = 5'd2,
    OP_MUL   = 5'd3,
    OP_DIV   = 5'd4,
    OP_AND   = 5'd5,
    OP_OR    = 5'd6,
    OP_XOR   = 5'd7,
    OP_SHL   = 5'd8,
    OP_SHR   = 5'd9,
    OP_SLT   = 5'd10,
    OP_SLE   = 5'd11,
    OP_SEQ   = 5'd12,
    OP_LOAD  = 5'd13,
    OP_STORE = 5'd14,
    OP_JMP   = 5'd15,
    OP_BRAZ  = 5'd16,
    OP_BRANZ = 5'd17
  } opcode_t;

  localparam logic CFG_ALU_COST  = 1'b0;
  localparam logic CFG_SLOW_COST = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_MEM,
    ST_OUT
  } state_t;

  // divider interface
  typedef struct packed {
    logic          start;
    logic [DW-1:0] num;
    logic [DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] quot;
  } div_rsp_t;

endpackage

// ----- sv/simple_risc_instruction_execute_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simple_risc_instruction_execute_top
// Decodes and executes one instruction per request on a register file and a
// data memory, reporting next pc, write-back, cycle total and flags.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_stall, instr_word   | request in
//  out     | out_valid, out_stall, results    | result out
//  cfg     | cfg_we, cfg_index, cfg_data      | write only
//
// Each instruction passes through register read, memory read, execute and
// output; a divide also waits for the bit-serial divider.
// Reset clears control state, then a clearing pass zeroes every word of the
// data memory; the 32 registers carry valid bits.
// A stalled output holds the result; no new request is taken until it leaves.
// ----------------------------------------------------------------------------
module simple_risc_instruction_execute_top #(
  parameter int unsigned DATA_DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [7:0]               cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [31:0]              instr_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [sri_pkg::PC_W-1:0] next_pc,
  output logic                     reg_written,
  output logic [4:0]               dest_index,
  output logic signed [15:0]       dest_value,
  output logic [31:0]              cycle_total,
  output logic                     halted,
  output logic                     div_zero
);
  import sri_pkg::*;

  localparam int unsigned AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

  logic [7:0] alu_cost, slow_cost;
  always_ff @(posedge clk) begin
    if (rst) begin
      alu_cost  <= 8'd1;
      slow_cost <= 8'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALU_COST:  alu_cost  <= cfg_data;
        CFG_SLOW_COST: slow_cost <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic [PC_W-1:0] pc;
  logic [31:0]     acc;
  logic            stopped;
  logic [31:0]     iw;
  logic            clearing;
  logic [AW:0]     clr_cnt;

  // register file: memory with valid bits
  logic [DW-1:0] rf [32];
  logic [31:0]   rf_vld;
  logic [DW-1:0] rf_a_q, rf_b_q, rf_c_q;
  logic          rf_a_v, rf_b_v, rf_c_v;
  logic [RW-1:0] ra_sel, rb_sel, rc_sel;
  logic          rf_we;
  logic [RW-1:0] rf_wa;
  logic [DW-1:0] rf_wd;

  logic [DW-1:0] dm [DATA_DEPTH];
  logic [DW-1:0] dm_q;
  logic          dm_we;
  logic [AW-1:0] dm_wa;
  logic [DW-1:0] dm_wd;
  logic [AW-1:0] dm_ra;

  logic [4:0] op;
  assign op = iw[31:27];

  // first cycle reads from instruction on port; use latched word otherwise
  logic [31:0] rd_w;
  assign rd_w   = (state == ST_IDLE) ? instr_word : iw;
  assign ra_sel = (rd_w[31:27] == OP_BRAZ || rd_w[31:27] == OP_BRANZ) ?
                  rd_w[26:22] : rd_w[26:22];
  assign rb_sel = rd_w[9:5];
  assign rc_sel = rd_w[4:0];

  always_ff @(posedge clk) begin
    rf_a_q <= rf[ra_sel];
    rf_b_q <= rf[rb_sel];
    rf_c_q <= rf[rc_sel];
    if (rf_we) rf[rf_wa] <= rf_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
      rf_a_v <= 1'b0;
      rf_b_v <= 1'b0;
      rf_c_v <= 1'b0;
    end else begin
      rf_a_v <= rf_vld[ra_sel];
      rf_b_v <= rf_vld[rb_sel];
      rf_c_v <= rf_vld[rc_sel];
      if (rf_we) rf_vld[rf_wa] <= 1'b1;
    end
  end

  logic [DW-1:0] va, vb, vc, opb;
  assign va  = rf_a_v ? rf_a_q : '0;
  assign vb  = rf_b_v ? rf_b_q : '0;
  assign vc  = rf_c_v ? rf_c_q : '0;
  assign opb = iw[21] ? iw[20:5] : vb;

  logic [DW-1:0] addr;
  logic          addr_ok;
  assign addr    = va + opb;
  assign addr_ok = ({16'd0, addr} < 32'(DATA_DEPTH));
  assign dm_ra   = addr[AW-1:0];

  always_ff @(posedge clk) begin
    dm_q <= dm[dm_ra];
    if (dm_we) dm[dm_wa] <= dm_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == (AW + 1)'(DATA_DEPTH - 1)) clearing <= 1'b0;
    end
  end

  div_req_t dreq;
  div_rsp_t drsp;
  sri_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // execute
  logic [DW-1:0]        r;
  logic [DW-1:0]        mul_lo;
  logic [3:0]           sh;
  logic                 wr, dz, brz;
  logic [PC_W-1:0]      npc;
  logic [7:0]           cost;
  logic [32:0]          acc_sum;
  assign mul_lo = va * opb;
  assign sh = (opb >= 16'd15) ? 4'd15 : opb[3:0];

  always_comb begin
    r    = '0;
    wr   = 1'b0;
    dz   = 1'b0;
    npc  = pc + 1'b1;
    cost = 8'd0;
    brz  = (va == '0);
    case (op)
      OP_ADD:   r = va + opb;
      OP_SUB:   r = va - opb;
      OP_MUL:   r = mul_lo;
      OP_DIV:   begin
                  dz = (opb == '0);
                  r  = dz ? '0 : drsp.quot;
                end
      OP_AND:   r = va & opb;
      OP_OR:    r = va | opb;
      OP_XOR:   r = va ^ opb;
      OP_SHL:   r = (opb >= 16'd16) ? '0 : (va << opb[3:0]);
      OP_SHR:   r = $signed(va) >>> sh;
      OP_SLT:   r = {15'd0, $signed(va) <  $signed(opb)};
      OP_SLE:   r = {15'd0, $signed(va) <= $signed(opb)};
      OP_SEQ:   r = {15'd0, va == opb};
      OP_LOAD:  r = addr_ok ? dm_q : '0;
      OP_JMP:   begin
                  r   = DW'(pc + 1'b1);
                  npc = iw[26] ? {1'b0, iw[24:5]} : {5'd0, vb};
                end
      OP_BRAZ:  if (brz) npc = iw[20:0];
      OP_BRANZ: if (!brz) npc = iw[20:0];
      default:  ;
    endcase
    if (op >= OP_ADD && op <= OP_LOAD) wr = 1'b1;
    if (op == OP_JMP) wr = 1'b1;
    if (op >= OP_ADD && op <= OP_SEQ) cost = alu_cost;
    else if (op >= OP_LOAD && op <= OP_BRANZ) cost = slow_cost;
  end

  assign acc_sum = {1'b0, acc} + {25'd0, cost};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid && !in_stall) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_DIV;
      ST_DIV:  state_next = (!stopped && op == OP_DIV && opb != '0) ? ST_MEM : ST_OUT;
      ST_MEM:  if (drsp.done) state_next = ST_OUT;
      ST_OUT:  if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  logic do_exec;
  always_comb begin
    in_stall   = (state != ST_IDLE) || clearing;
    dreq.start = (state == ST_DIV) && (op == OP_DIV) && (opb != '0) && !stopped;
    dreq.num   = va;
    dreq.den   = opb;
    do_exec    = !stopped &&
                 (((state == ST_DIV) && !(op == OP_DIV && opb != '0)) ||
                  ((state == ST_MEM) && drsp.done));
    rf_we      = do_exec && wr;
    rf_wa      = (op == OP_JMP) ? iw[4:0] : iw[4:0];
    rf_wd      = r;
    dm_we      = clearing || (do_exec && op == OP_STORE && addr_ok);
    dm_wa      = clearing ? clr_cnt[AW-1:0] : addr[AW-1:0];
    dm_wd      = clearing ? '0 : vc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      acc       <= '0;
      stopped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_valid && !in_stall) iw <= instr_word;
      if (state == ST_DIV && stopped) begin
        out_valid   <= 1'b1;
        next_pc     <= pc;
        reg_written <= 1'b0;
        dest_index  <= '0;
        dest_value  <= '0;
        cycle_total <= acc;
        halted      <= 1'b1;
        div_zero    <= 1'b0;
      end else if (do_exec) begin
        pc          <= npc;
        acc         <= acc_sum[32] ? 32'hffffffff : acc_sum[31:0];
        if (op == OP_STOP) stopped <= 1'b1;
        out_valid   <= 1'b1;
        next_pc     <= npc;
        reg_written <= wr;
        dest_index  <= wr ? iw[4:0] : 5'd0;
        dest_value  <= wr ? r : '0;
        cycle_total <= acc_sum[32] ? 32'hffffffff : acc_sum[31:0];
        halted      <= (op == OP_STOP);
        div_zero    <= dz;
      end else if (state == ST_OUT && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/sri_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sri_div
// Signed 16-bit restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module sri_div (
  input  logic              clk,
  input  logic              rst,
  input  sri_pkg::div_req_t req,
  output sri_pkg::div_rsp_t rsp
);
  import sri_pkg::*;

  logic [DW-1:0] rem;
  logic [DW-1:0] quo;
  logic [DW-1:0] dmag;
  logic          neg;
  logic [4:0]    cnt;
  logic          busy;
  logic          done;
  logic [DW:0]   trial;
  logic [DW-1:0] rem_sh;

  assign rem_sh = {rem[DW-2:0], quo[DW-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        rem  <= '0;
        quo  <= req.num[DW-1] ? (~req.num + 1'b1) : req.num;
        dmag <= req.den[DW-1] ? (~req.den + 1'b1) : req.den;
        neg  <= req.num[DW-1] ^ req.den[DW-1];
      end else if (busy) begin
        if (trial[DW]) begin
          rem <= rem_sh;
          quo <= {quo[DW-2:0], 1'b0};
        end else begin
          rem <= trial[DW-1:0];
          quo <= {quo[DW-2:0], 1'b1};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, (neg ? (~quo + 1'b1) : quo)};

endmodule
